FILE: rtl/thldq_pkg.sv
// Shared widths, table depths and table select codes for the two-hop
// label distance query unit. No dependencies.
`default_nettype none
package thldq_pkg;
    localparam int NODE_W   = 10;
    localparam int EULER_W  = 11;
    localparam int DEPTH_W  = 7;
    localparam int DIST_W   = 31;
    localparam int IDX_W    = 6;
    localparam int COUNT_W  = 7;
    localparam int LEVEL_W  = 4;
    localparam int ROW_W    = 11;
    localparam int COL_W    = 6;
    localparam int RESULT_W = 32;

    localparam int NODES         = 1024;
    localparam int EULER_LEN     = 2048;
    localparam int SPARSE_LEVELS = 12;
    localparam int SPARSE_DEPTH  = SPARSE_LEVELS * EULER_LEN;
    localparam int TREE_DEPTH    = 64;
    localparam int HUB_SLOTS     = 64;
    localparam int PAIR_DEPTH    = NODES * TREE_DEPTH;

    typedef enum logic [2:0] {
        TBL_VERTEX_NODE = 3'd0,
        TBL_EULER_POS   = 3'd1,
        TBL_DEPTH       = 3'd2,
        TBL_SPARSE_MIN  = 3'd3,
        TBL_ANC_DIST    = 3'd4,
        TBL_OWN_INDEX   = 3'd5,
        TBL_HUB_POS     = 3'd6,
        TBL_HUB_COUNT   = 3'd7
    } table_sel_t;

    localparam logic ACT_QUERY = 1'b0;
    localparam logic ACT_WRITE = 1'b1;
endpackage
`default_nettype wire

FILE: rtl/thldq_if.sv
// Channel interfaces of the two-hop label distance query unit: input
// item, result and configuration write. Depends on thldq_pkg.
`default_nettype none
interface thldq_item_if;
    logic                           valid;
    logic                           ready;
    logic                           action;
    logic [2:0]                     table_select;
    logic [thldq_pkg::ROW_W-1:0]    entry_row;
    logic [thldq_pkg::COL_W-1:0]    entry_col;
    logic [thldq_pkg::DIST_W-1:0]   entry_value;
    logic [thldq_pkg::NODE_W-1:0]   source_vertex;
    logic [thldq_pkg::NODE_W-1:0]   target_vertex;

    modport source (output valid, action, table_select, entry_row, entry_col,
                    entry_value, source_vertex, target_vertex, input ready);
    modport sink (input valid, action, table_select, entry_row, entry_col,
                  entry_value, source_vertex, target_vertex, output ready);
endinterface

interface thldq_result_if;
    logic                            valid;
    logic                            ready;
    logic [thldq_pkg::RESULT_W-1:0]  distance;
    logic                            ancestor_case;

    modport source (output valid, distance, ancestor_case, input ready);
    modport sink (input valid, distance, ancestor_case, output ready);
endinterface

interface thldq_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [thldq_pkg::RESULT_W-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/two_hop_label_distance_query_unit.sv
// Two-hop label distance query unit: index tables in on-chip memories and
// the query sequencer. Depends on thldq_pkg and thldq_if.
//
// A write beat stores one table entry. A query beat with equal vertices goes
// to the done state; others pass the node, Euler, sparse and depth states;
// an ancestor query then reads its distance; a hub query reads the common
// ancestor's hub count (capped at 64) and per hub one hub position and then
// two ancestor distances from the dual-read distance memory. The unit works
// on one query at a time and takes the next beat while a result still waits
// on the output register. The tables have no reset.
`default_nettype none
module two_hop_label_distance_query_unit (
    input  wire                   clk,
    input  wire                   rst_n,
    thldq_item_if.sink            items,
    thldq_result_if.source        results,
    thldq_cfg_if.sink             cfg
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_NODE, ST_EUL, ST_SPR, ST_DEP,
        ST_ANC, ST_CNT, ST_HPOS, ST_HSUM, ST_DONE
    } state_t;

    state_t                            state_reg, state_next;
    logic [thldq_pkg::RESULT_W-1:0]    unreach_reg;
    logic                              out_valid_reg;
    logic [thldq_pkg::RESULT_W-1:0]    out_dist_reg;
    logic                              out_anc_reg;
    logic [thldq_pkg::RESULT_W-1:0]    res_reg, res_next;
    logic                              anc_reg, anc_next;
    logic [thldq_pkg::NODE_W-1:0]      x_reg, y_reg, a_reg, b_reg, lca_reg;
    logic [thldq_pkg::IDX_W-1:0]       own_x_reg, own_y_reg;
    logic [thldq_pkg::COUNT_W-1:0]     cnt_reg, i_reg;

    // memories
    logic [thldq_pkg::NODE_W-1:0]  vtn_mem [0:thldq_pkg::NODES-1];
    logic [thldq_pkg::EULER_W-1:0] eul_mem [0:thldq_pkg::NODES-1];
    logic [thldq_pkg::DEPTH_W-1:0] dep_mem [0:thldq_pkg::NODES-1];
    logic [thldq_pkg::NODE_W-1:0]  spr_mem [0:thldq_pkg::SPARSE_DEPTH-1];
    logic [thldq_pkg::DIST_W-1:0]  dst_mem [0:thldq_pkg::PAIR_DEPTH-1];
    logic [thldq_pkg::IDX_W-1:0]   own_mem [0:thldq_pkg::NODES-1];
    logic [thldq_pkg::IDX_W-1:0]   hpo_mem [0:thldq_pkg::PAIR_DEPTH-1];
    logic [thldq_pkg::COUNT_W-1:0] hct_mem [0:thldq_pkg::NODES-1];

    logic [thldq_pkg::NODE_W-1:0]  vtn_qa, vtn_qb;
    logic [thldq_pkg::EULER_W-1:0] eul_qa, eul_qb;
    logic [thldq_pkg::DEPTH_W-1:0] dep_qa, dep_qb;
    logic [thldq_pkg::NODE_W-1:0]  spr_qa, spr_qb;
    logic [thldq_pkg::DIST_W-1:0]  dst_qa, dst_qb;
    logic [thldq_pkg::IDX_W-1:0]   own_qa, own_qb;
    logic [thldq_pkg::IDX_W-1:0]   hpo_q;
    logic [thldq_pkg::COUNT_W-1:0] hct_q;

    logic [14:0] spr_addr_a, spr_addr_b;
    logic [15:0] dst_addr_a, dst_addr_b, hpo_addr;

    logic in_acc, wr_acc, q_acc, row_in_nodes;
    assign items.ready  = (state_reg == ST_IDLE);
    assign in_acc       = items.valid && items.ready;
    assign wr_acc       = in_acc && (items.action == thldq_pkg::ACT_WRITE);
    assign q_acc        = in_acc && (items.action == thldq_pkg::ACT_QUERY);
    assign row_in_nodes = (items.entry_row[thldq_pkg::ROW_W-1] == 1'b0);

    assign cfg.ready = 1'b1;
    assign results.valid         = out_valid_reg;
    assign results.distance      = out_dist_reg;
    assign results.ancestor_case = out_anc_reg;

    // window of the range minimum
    logic [thldq_pkg::EULER_W-1:0] p_lo, p_hi, span, p_right;
    logic [thldq_pkg::LEVEL_W-1:0] lvl;
    always_comb
    begin
        p_lo = (eul_qa > eul_qb) ? eul_qb : eul_qa;
        p_hi = (eul_qa > eul_qb) ? eul_qa : eul_qb;
        span = p_hi - p_lo;
        lvl  = '0;
        for (int n = 1; n < thldq_pkg::EULER_W; n++)
        begin
            if (span[n])
            begin
                lvl = thldq_pkg::LEVEL_W'(n);
            end
        end
        p_right = p_hi - (thldq_pkg::EULER_W'(1) << lvl) + thldq_pkg::EULER_W'(1);
        spr_addr_a = {lvl, p_lo};
        spr_addr_b = {lvl, p_right};
    end

    // common ancestor and ancestor-case flag
    logic [thldq_pkg::NODE_W-1:0] lca_c;
    logic                         is_anc;
    assign lca_c  = (dep_qa < dep_qb) ? a_reg : b_reg;
    assign is_anc = (lca_c == x_reg) || (lca_c == y_reg);

    // hub sum, saturated, and running minimum
    logic [thldq_pkg::RESULT_W:0]   hsum;
    logic [thldq_pkg::RESULT_W-1:0] hsat, hmin;
    logic [thldq_pkg::COUNT_W-1:0]  i_inc, cnt_clamp;
    assign hsum  = {2'b00, dst_qa} + {2'b00, dst_qb};
    assign hsat  = hsum[thldq_pkg::RESULT_W] ? '1 : hsum[thldq_pkg::RESULT_W-1:0];
    assign hmin  = (hsat < res_reg) ? hsat : res_reg;
    assign i_inc = i_reg + thldq_pkg::COUNT_W'(1);
    assign cnt_clamp = (hct_q > thldq_pkg::COUNT_W'(thldq_pkg::HUB_SLOTS))
                     ? thldq_pkg::COUNT_W'(thldq_pkg::HUB_SLOTS) : hct_q;

    // address select for the distance and hub memories
    always_comb
    begin
        if (state_reg == ST_DEP)
        begin
            dst_addr_a = (lca_c == x_reg) ? {y_reg, own_x_reg} : {x_reg, own_y_reg};
        end
        else
        begin
            dst_addr_a = {x_reg, hpo_q};
        end
        dst_addr_b = {y_reg, hpo_q};
        hpo_addr   = (state_reg == ST_CNT) ? {lca_reg, 6'd0}
                                           : {lca_reg, i_inc[thldq_pkg::IDX_W-1:0]};
    end

    // table writes and registered reads
    always_ff @(posedge clk)
    begin
        if (wr_acc && row_in_nodes)
        begin
            case (items.table_select)
                thldq_pkg::TBL_VERTEX_NODE:
                    vtn_mem[items.entry_row[9:0]] <= items.entry_value[9:0];
                thldq_pkg::TBL_EULER_POS:
                    eul_mem[items.entry_row[9:0]] <= items.entry_value[10:0];
                thldq_pkg::TBL_DEPTH:
                    dep_mem[items.entry_row[9:0]] <= items.entry_value[6:0];
                thldq_pkg::TBL_OWN_INDEX:
                    own_mem[items.entry_row[9:0]] <= items.entry_value[5:0];
                thldq_pkg::TBL_HUB_COUNT:
                    hct_mem[items.entry_row[9:0]] <= items.entry_value[6:0];
                default:
                begin
                end
            endcase
        end
        vtn_qa <= vtn_mem[items.source_vertex];
        vtn_qb <= vtn_mem[items.target_vertex];
        eul_qa <= eul_mem[vtn_qa];
        eul_qb <= eul_mem[vtn_qb];
        own_qa <= own_mem[vtn_qa];
        own_qb <= own_mem[vtn_qb];
        dep_qa <= dep_mem[spr_qa];
        dep_qb <= dep_mem[spr_qb];
        hct_q  <= hct_mem[lca_c];
    end

    always_ff @(posedge clk)
    begin
        if (wr_acc && items.table_select == thldq_pkg::TBL_SPARSE_MIN
            && items.entry_col < thldq_pkg::COL_W'(thldq_pkg::SPARSE_LEVELS))
        begin
            spr_mem[{items.entry_col[3:0], items.entry_row}] <= items.entry_value[9:0];
        end
        spr_qa <= spr_mem[spr_addr_a];
        spr_qb <= spr_mem[spr_addr_b];
    end

    always_ff @(posedge clk)
    begin
        if (wr_acc && row_in_nodes && items.table_select == thldq_pkg::TBL_ANC_DIST)
        begin
            dst_mem[{items.entry_row[9:0], items.entry_col}] <= items.entry_value;
        end
        dst_qa <= dst_mem[dst_addr_a];
        dst_qb <= dst_mem[dst_addr_b];
    end

    always_ff @(posedge clk)
    begin
        if (wr_acc && row_in_nodes && items.table_select == thldq_pkg::TBL_HUB_POS)
        begin
            hpo_mem[{items.entry_row[9:0], items.entry_col}] <= items.entry_value[5:0];
        end
        hpo_q <= hpo_mem[hpo_addr];
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        anc_next   = anc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_acc)
                begin
                    if (items.source_vertex == items.target_vertex)
                    begin
                        res_next   = '0;
                        anc_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_NODE;
                    end
                end
            end
            ST_NODE: state_next = ST_EUL;
            ST_EUL:  state_next = ST_SPR;
            ST_SPR:  state_next = ST_DEP;
            ST_DEP:  state_next = is_anc ? ST_ANC : ST_CNT;
            ST_ANC:
            begin
                res_next   = {1'b0, dst_qa};
                anc_next   = 1'b1;
                state_next = ST_DONE;
            end
            ST_CNT:
            begin
                res_next   = unreach_reg;
                anc_next   = 1'b0;
                state_next = (cnt_clamp == '0) ? ST_DONE : ST_HPOS;
            end
            ST_HPOS: state_next = ST_HSUM;
            ST_HSUM:
            begin
                res_next   = hmin;
                state_next = (i_inc == cnt_reg) ? ST_DONE : ST_HPOS;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer state, working registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            unreach_reg   <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                unreach_reg <= cfg.data;
            end
            if (state_reg == ST_DONE && (!out_valid_reg || results.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        anc_reg <= anc_next;
        if (state_reg == ST_NODE)
        begin
            x_reg <= vtn_qa;
            y_reg <= vtn_qb;
        end
        if (state_reg == ST_EUL)
        begin
            own_x_reg <= own_qa;
            own_y_reg <= own_qb;
        end
        if (state_reg == ST_SPR)
        begin
            a_reg <= spr_qa;
            b_reg <= spr_qb;
        end
        if (state_reg == ST_DEP)
        begin
            lca_reg <= lca_c;
        end
        if (state_reg == ST_CNT)
        begin
            cnt_reg <= cnt_clamp;
            i_reg   <= '0;
        end
        if (state_reg == ST_HSUM)
        begin
            i_reg <= i_inc;
        end
        if (state_reg == ST_DONE && (!out_valid_reg || results.ready))
        begin
            out_dist_reg <= res_reg;
            out_anc_reg  <= anc_reg;
        end
    end
endmodule
`default_nettype wire

FILE: sim/two_hop_label_distance_query_unit_tb.sv
// Self-checking testbench for two_hop_label_distance_query_unit: directed table,
// index load, then random queries and table writes under several register settings.
// Depends on thldq_pkg, thldq_if and the unit itself.
`timescale 1ns / 1ps
module two_hop_label_distance_query_unit_tb;

    typedef struct {
        logic                  action;
        thldq_pkg::table_sel_t sel;
        logic [10:0]           row;
        logic [5:0]            col;
        logic [30:0]           val;
        logic [9:0]            src;
        logic [9:0]            dst;
        bit                    has_exp;
        logic [31:0]           exp_dist;
        logic                  exp_anc;
    } beat_t;

    typedef struct {
        logic [31:0] dist_value;
        logic        anc;
    } answer_t;

    // Loaded region of the index: vertices 0..15 on tree nodes 0..7, label columns 0..15
    localparam int LOAD_VERTS = 16;
    localparam int LOAD_NODES = 8;
    localparam int LOAD_EULER = 16;
    localparam int LOAD_LEVELS = 4;
    localparam int LOAD_COLS = 16;
    localparam int DRAIN_CYCLES = 200;
    localparam int WATCHDOG_LIMIT = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    thldq_item_if   items ();
    thldq_result_if results ();
    thldq_cfg_if    cfg ();

    two_hop_label_distance_query_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items.sink),
        .results (results.source),
        .cfg     (cfg.sink)
    );

    always #5 clk = ~clk;

    // Shadow copy of the index tables with written flags
    bit [9:0]  vtx_node [thldq_pkg::NODES];
    bit        vtx_node_ok [thldq_pkg::NODES];
    bit [10:0] euler_pos [thldq_pkg::NODES];
    bit        euler_pos_ok [thldq_pkg::NODES];
    bit [6:0]  node_dep [thldq_pkg::NODES];
    bit        node_dep_ok [thldq_pkg::NODES];
    bit [9:0]  sparse_node [thldq_pkg::SPARSE_DEPTH];
    bit        sparse_node_ok [thldq_pkg::SPARSE_DEPTH];
    bit [30:0] anc_dist [thldq_pkg::PAIR_DEPTH];
    bit        anc_dist_ok [thldq_pkg::PAIR_DEPTH];
    bit [5:0]  own_idx [thldq_pkg::NODES];
    bit        own_idx_ok [thldq_pkg::NODES];
    bit [5:0]  hub_pos [thldq_pkg::NODES * thldq_pkg::HUB_SLOTS];
    bit        hub_pos_ok [thldq_pkg::NODES * thldq_pkg::HUB_SLOTS];
    bit [6:0]  hub_cnt [thldq_pkg::NODES];
    bit        hub_cnt_ok [thldq_pkg::NODES];
    logic [31:0] unreachable = 32'hFFFF_FFFF;

    answer_t expected_answers[$];
    int      errors = 0;
    int      idle_count = 0;
    bit      gap_on = 1'b1;
    bit      stall_on = 1'b1;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Apply a table write to the shadow index, masking and bounds as the unit does
    function automatic void store_entry(input thldq_pkg::table_sel_t sel,
                                        input logic [10:0] row,
                                        input logic [5:0] col, input logic [30:0] v);
        case (sel)
            thldq_pkg::TBL_VERTEX_NODE:
                if (row < thldq_pkg::NODES)
                begin
                    vtx_node[row] = v[9:0];
                    vtx_node_ok[row] = 1;
                end
            thldq_pkg::TBL_EULER_POS:
                if (row < thldq_pkg::NODES)
                begin
                    euler_pos[row] = v[10:0];
                    euler_pos_ok[row] = 1;
                end
            thldq_pkg::TBL_DEPTH:
                if (row < thldq_pkg::NODES)
                begin
                    node_dep[row] = v[6:0];
                    node_dep_ok[row] = 1;
                end
            thldq_pkg::TBL_SPARSE_MIN:
                if (col < thldq_pkg::SPARSE_LEVELS)
                begin
                    sparse_node[col * thldq_pkg::EULER_LEN + row] = v[9:0];
                    sparse_node_ok[col * thldq_pkg::EULER_LEN + row] = 1;
                end
            thldq_pkg::TBL_ANC_DIST:
                if (row < thldq_pkg::NODES)
                begin
                    anc_dist[row * thldq_pkg::TREE_DEPTH + col] = v;
                    anc_dist_ok[row * thldq_pkg::TREE_DEPTH + col] = 1;
                end
            thldq_pkg::TBL_OWN_INDEX:
                if (row < thldq_pkg::NODES)
                begin
                    own_idx[row] = v[5:0];
                    own_idx_ok[row] = 1;
                end
            thldq_pkg::TBL_HUB_POS:
                if (row < thldq_pkg::NODES)
                begin
                    hub_pos[row * thldq_pkg::HUB_SLOTS + col] = v[5:0];
                    hub_pos_ok[row * thldq_pkg::HUB_SLOTS + col] = 1;
                end
            default:
                if (row < thldq_pkg::NODES)
                begin
                    hub_cnt[row] = v[6:0];
                    hub_cnt_ok[row] = 1;
                end
        endcase
    endfunction

    // Work out the distance answer; returns 0 when the query would touch an unwritten entry
    function automatic bit compute_distance(input logic [9:0] s, input logic [9:0] d,
                                            output answer_t ans);
        bit [9:0] x, y, a, b, lca, up, down;
        bit [10:0] p, q, t;
        int len, j, k, cnt, i, ia, ib;
        bit [5:0] h;
        bit [32:0] sum;
        bit [31:0] best;
        bit ok;
        ans.dist_value = '0;
        ans.anc = 1'b0;
        if (s == d) return 1'b1;
        ok = vtx_node_ok[s] && vtx_node_ok[d];
        x = vtx_node[s];
        y = vtx_node[d];
        ok = ok && euler_pos_ok[x] && euler_pos_ok[y];
        p = euler_pos[x];
        q = euler_pos[y];
        if (p > q)
        begin
            t = p;
            p = q;
            q = t;
        end
        len = q - p + 1;
        j = 1;
        k = 0;
        while (len > 2 * j)
        begin
            j = j * 2;
            k++;
        end
        ia = k * thldq_pkg::EULER_LEN + p;
        ib = k * thldq_pkg::EULER_LEN + (q - j + 1);
        ok = ok && sparse_node_ok[ia] && sparse_node_ok[ib];
        a = sparse_node[ia];
        b = sparse_node[ib];
        ok = ok && node_dep_ok[a] && node_dep_ok[b];
        // equal depths take the right window's node
        lca = (node_dep[a] < node_dep[b]) ? a : b;
        if (lca == x || lca == y)
        begin
            up = (lca == x) ? x : y;
            down = (lca == x) ? y : x;
            ok = ok && own_idx_ok[up]
                 && anc_dist_ok[down * thldq_pkg::TREE_DEPTH + own_idx[up]];
            ans.dist_value = {1'b0, anc_dist[down * thldq_pkg::TREE_DEPTH + own_idx[up]]};
            ans.anc = 1'b1;
            return ok;
        end
        ok = ok && hub_cnt_ok[lca];
        cnt = (hub_cnt[lca] > thldq_pkg::HUB_SLOTS) ? thldq_pkg::HUB_SLOTS : hub_cnt[lca];
        best = unreachable;
        for (i = 0; i < cnt; i++)
        begin
            ok = ok && hub_pos_ok[lca * thldq_pkg::HUB_SLOTS + i];
            h = hub_pos[lca * thldq_pkg::HUB_SLOTS + i];
            ok = ok && anc_dist_ok[x * thldq_pkg::TREE_DEPTH + h]
                 && anc_dist_ok[y * thldq_pkg::TREE_DEPTH + h];
            sum = anc_dist[x * thldq_pkg::TREE_DEPTH + h]
                + anc_dist[y * thldq_pkg::TREE_DEPTH + h];
            if (sum > 33'hFFFF_FFFF) sum = 33'hFFFF_FFFF;
            if (sum[31:0] < best) best = sum[31:0];
        end
        ans.dist_value = best;
        return ok;
    endfunction

    // Drive one item beat; entered and left at a falling edge
    task automatic send_beat(input beat_t bt);
        answer_t ans;
        while (gap_on && $urandom_range(0, 99) < 35)
        begin
            items.valid <= 1'b0;
            @(negedge clk);
        end
        items.valid         <= 1'b1;
        items.action        <= bt.action;
        items.table_select  <= bt.sel;
        items.entry_row     <= bt.row;
        items.entry_col     <= bt.col;
        items.entry_value   <= bt.val;
        items.source_vertex <= bt.src;
        items.target_vertex <= bt.dst;
        @(posedge clk);
        while (!items.ready) @(posedge clk);
        if (bt.action == thldq_pkg::ACT_WRITE)
        begin
            store_entry(bt.sel, bt.row, bt.col, bt.val);
        end
        else if (bt.has_exp)
        begin
            ans.dist_value = bt.exp_dist;
            ans.anc = bt.exp_anc;
            expected_answers.insert(expected_answers.size(), ans);
        end
        else
        begin
            void'(compute_distance(bt.src, bt.dst, ans));
            expected_answers.insert(expected_answers.size(), ans);
        end
        @(negedge clk);
    endtask

    task automatic write_unreachable(input logic [31:0] v);
        cfg.valid <= 1'b1;
        cfg.data  <= v;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        unreachable = v;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // Hold until every answer is back and any trailing write has settled
    task automatic drain();
        items.valid <= 1'b0;
        while (expected_answers.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic beat_t write_beat(input thldq_pkg::table_sel_t sel, input int row,
                                         input int col, input logic [30:0] v);
        beat_t bt;
        bt = '{thldq_pkg::ACT_WRITE, sel, row[10:0], col[5:0], v, '0, '0, 1'b0, '0, 1'b0};
        return bt;
    endfunction

    // Random write that keeps the loaded region self-consistent; wide upper bits are masked off
    function automatic beat_t random_write();
        thldq_pkg::table_sel_t sel;
        logic [30:0] noise;
        int row, col;
        sel = thldq_pkg::table_sel_t'($urandom_range(0, 7));
        noise = 31'($urandom);
        col = $urandom_range(0, 63);
        row = $urandom_range(0, LOAD_NODES - 1);
        if ($urandom_range(0, 9) == 0)
        begin
            // out of range: dropped by the unit
            if (sel == thldq_pkg::TBL_SPARSE_MIN)
                col = $urandom_range(thldq_pkg::SPARSE_LEVELS, 63);
            else
                row = $urandom_range(thldq_pkg::NODES, 2047);
            return write_beat(sel, row, col, noise);
        end
        case (sel)
            thldq_pkg::TBL_VERTEX_NODE:
                return write_beat(sel, $urandom_range(0, LOAD_VERTS - 1), col,
                                  {noise[30:10], 10'($urandom_range(0, LOAD_NODES - 1))});
            thldq_pkg::TBL_EULER_POS:
                return write_beat(sel, row, col,
                                  {noise[30:11], 11'($urandom_range(0, LOAD_EULER - 1))});
            thldq_pkg::TBL_DEPTH:
                return write_beat(sel, row, col, {noise[30:7], 7'($urandom_range(0, 3))});
            thldq_pkg::TBL_SPARSE_MIN:
                return write_beat(sel, $urandom_range(0, LOAD_EULER - 1),
                                  $urandom_range(0, LOAD_LEVELS - 1),
                                  {noise[30:10], 10'($urandom_range(0, LOAD_NODES - 1))});
            thldq_pkg::TBL_OWN_INDEX, thldq_pkg::TBL_HUB_POS:
                return write_beat(sel, row, col,
                                  {noise[30:6], 6'($urandom_range(0, LOAD_COLS - 1))});
            thldq_pkg::TBL_HUB_COUNT:
                return write_beat(sel, row, col,
                                  {noise[30:7], 7'($urandom_range(0, 9) == 0 ?
                                      $urandom_range(0, 127) : $urandom_range(0, 6))});
            default:
                return write_beat(sel, row, col, noise);
        endcase
    endfunction

    function automatic beat_t random_query();
        beat_t bt;
        answer_t ans;
        int tries;
        bt = '{thldq_pkg::ACT_QUERY, thldq_pkg::TBL_VERTEX_NODE, 11'($urandom),
               6'($urandom), 31'($urandom), '0, '0, 1'b0, '0, 1'b0};
        if ($urandom_range(0, 9) == 0)
        begin
            bt.src = 10'($urandom_range(0, 1023));
            bt.dst = bt.src;
            return bt;
        end
        for (tries = 0; tries < 20; tries++)
        begin
            bt.src = 10'($urandom_range(0, LOAD_VERTS - 1));
            bt.dst = 10'($urandom_range(0, LOAD_VERTS - 1));
            if (compute_distance(bt.src, bt.dst, ans)) return bt;
        end
        bt.dst = bt.src;
        return bt;
    endfunction

    // Directed rows: equal vertices, masked and dropped writes, field extremes
    beat_t directed [] = '{
        '{thldq_pkg::ACT_QUERY, thldq_pkg::TBL_VERTEX_NODE, 11'd0, 6'd0, 31'd0, 10'd0, 10'd0,
          1'b1, 32'd0, 1'b0},
        '{thldq_pkg::ACT_QUERY, thldq_pkg::TBL_HUB_COUNT, 11'h7FF, 6'h3F, 31'h7FFF_FFFF,
          10'h3FF, 10'h3FF, 1'b1, 32'd0, 1'b0},
        '{thldq_pkg::ACT_QUERY, thldq_pkg::TBL_HUB_POS, 11'h555, 6'h2A, 31'h2AAA_AAAA,
          10'h2AA, 10'h2AA, 1'b1, 32'd0, 1'b0},
        '{thldq_pkg::ACT_WRITE, thldq_pkg::TBL_SPARSE_MIN, 11'd0, 6'd12, 31'h7FFF_FFFF,
          10'd0, 10'd0, 1'b0, 32'd0, 1'b0},
        '{thldq_pkg::ACT_WRITE, thldq_pkg::TBL_SPARSE_MIN, 11'h7FF, 6'h3F, 31'd1,
          10'd0, 10'd0, 1'b0, 32'd0, 1'b0},
        '{thldq_pkg::ACT_WRITE, thldq_pkg::TBL_ANC_DIST, 11'h7FF, 6'd0, 31'd5,
          10'd0, 10'd0, 1'b0, 32'd0, 1'b0},
        '{thldq_pkg::ACT_WRITE, thldq_pkg::TBL_VERTEX_NODE, 11'd1024, 6'd0, 31'd3,
          10'd0, 10'd0, 1'b0, 32'd0, 1'b0},
        '{thldq_pkg::ACT_WRITE, thldq_pkg::TBL_HUB_POS, 11'd2047, 6'd63, 31'd3,
          10'd0, 10'd0, 1'b0, 32'd0, 1'b0},
        '{thldq_pkg::ACT_WRITE, thldq_pkg::TBL_HUB_COUNT, 11'd1023, 6'd0, 31'h7FFF_FFFF,
          10'd0, 10'd0, 1'b0, 32'd0, 1'b0},
        '{thldq_pkg::ACT_WRITE, thldq_pkg::TBL_ANC_DIST, 11'd1023, 6'd63, 31'h7FFF_FFFF,
          10'd0, 10'd0, 1'b0, 32'd0, 1'b0},
        '{thldq_pkg::ACT_WRITE, thldq_pkg::TBL_HUB_POS, 11'd1023, 6'd63, 31'h7FFF_FFFF,
          10'd0, 10'd0, 1'b0, 32'd0, 1'b0},
        '{thldq_pkg::ACT_WRITE, thldq_pkg::TBL_OWN_INDEX, 11'd1023, 6'd0, 31'h7FFF_FFFF,
          10'd0, 10'd0, 1'b0, 32'd0, 1'b0},
        '{thldq_pkg::ACT_WRITE, thldq_pkg::TBL_DEPTH, 11'd1023, 6'd0, 31'h7FFF_FFFF,
          10'd0, 10'd0, 1'b0, 32'd0, 1'b0},
        '{thldq_pkg::ACT_WRITE, thldq_pkg::TBL_EULER_POS, 11'd1023, 6'd0, 31'h7FFF_FFFF,
          10'd0, 10'd0, 1'b0, 32'd0, 1'b0},
        '{thldq_pkg::ACT_WRITE, thldq_pkg::TBL_VERTEX_NODE, 11'd1023, 6'd0, 31'h7FFF_FFFF,
          10'd0, 10'd0, 1'b0, 32'd0, 1'b0},
        '{thldq_pkg::ACT_QUERY, thldq_pkg::TBL_VERTEX_NODE, 11'd0, 6'd0, 31'd0,
          10'd1023, 10'd1023, 1'b1, 32'd0, 1'b0}
    };

    // Result side: random back-pressure
    always @(negedge clk)
    begin
        results.ready <= stall_on ? ($urandom_range(0, 99) >= 35) : 1'b1;
    end

    // Compare each result beat against the oldest expected answer
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && results.valid && results.ready)
        begin
            if (expected_answers.size() == 0)
            begin
                report_mismatch("unexpected result", results.distance, 32'd0);
            end
            else
            begin
                want = expected_answers.pop_front();
                if (results.distance !== want.dist_value)
                    report_mismatch("distance", results.distance, want.dist_value);
                if (results.ancestor_case !== want.anc)
                    report_mismatch("ancestor_case", 32'(results.ancestor_case),
                                    32'(want.anc));
            end
        end
    end

    // Watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if ((items.valid && items.ready) || (results.valid && results.ready)
            || (cfg.valid && cfg.ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int i, n, ph, lvl;
        logic [31:0] phase_values [4];
        items.valid = 1'b0;
        items.action = thldq_pkg::ACT_QUERY;
        items.table_select = thldq_pkg::TBL_VERTEX_NODE;
        items.entry_row = '0;
        items.entry_col = '0;
        items.entry_value = '0;
        items.source_vertex = '0;
        items.target_vertex = '0;
        results.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed table
        foreach (directed[i]) send_beat(directed[i]);

        // Load the index region
        gap_on = 1'b0;
        for (i = 0; i < LOAD_VERTS; i++)
            send_beat(write_beat(thldq_pkg::TBL_VERTEX_NODE, i, 0,
                                 31'($urandom_range(0, LOAD_NODES - 1))));
        for (i = 0; i < LOAD_NODES; i++)
        begin
            send_beat(write_beat(thldq_pkg::TBL_EULER_POS, i, 0,
                                 31'($urandom_range(0, LOAD_EULER - 1))));
            send_beat(write_beat(thldq_pkg::TBL_DEPTH, i, 0,
                                 31'((i == 0) ? 127 : $urandom_range(0, 3))));
            send_beat(write_beat(thldq_pkg::TBL_OWN_INDEX, i, 0,
                                 31'($urandom_range(0, LOAD_COLS - 1))));
            send_beat(write_beat(thldq_pkg::TBL_HUB_COUNT, i, 0,
                                 31'((i == 1) ? 0 : (i == 2) ? 127 : $urandom_range(1, 6))));
            for (n = 0; n < LOAD_COLS; n++)
                send_beat(write_beat(thldq_pkg::TBL_ANC_DIST, i, n,
                                     (n == 0) ? 31'h7FFF_FFFF : (n == 1) ? 31'd0 :
                                     31'($urandom_range(0, 3) == 0 ? $urandom
                                                                   : $urandom_range(0, 999))));
            // the node with an oversized hub count gets every slot
            for (n = 0; n < ((i == 2) ? thldq_pkg::HUB_SLOTS : LOAD_COLS); n++)
                send_beat(write_beat(thldq_pkg::TBL_HUB_POS, i, n,
                                     31'($urandom_range(0, LOAD_COLS - 1))));
        end
        for (lvl = 0; lvl < LOAD_LEVELS; lvl++)
            for (i = 0; i < LOAD_EULER; i++)
                send_beat(write_beat(thldq_pkg::TBL_SPARSE_MIN, i, lvl,
                                     31'($urandom_range(0, LOAD_NODES - 1))));

        // Random phases under different unreachable values and idling
        phase_values = '{32'd0, 32'($urandom), 32'hFFFF_FFFF, 32'd1};
        for (ph = 0; ph < 4; ph++)
        begin
            drain();
            write_unreachable(phase_values[ph]);
            gap_on = (ph != 1);
            stall_on = (ph != 1);
            for (i = 0; i < 200; i++)
                send_beat(($urandom_range(0, 99) < 75) ? random_query() : random_write());
        end
        drain();

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

FILE: sim.f
rtl/thldq_pkg.sv
rtl/thldq_if.sv
rtl/two_hop_label_distance_query_unit.sv
sim/two_hop_label_distance_query_unit_tb.sv
